// ----- rtl/m3inv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_pkg: shared types and constants for the 3x3 matrix inverse
// Field structs, queue entry layout, cofactor index table and saturation.
// ----------------------------------------------------------------------------
package m3inv_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int EW           = 32;              // element width
    localparam int CW           = 2 * EW;          // cofactor width
    localparam int MW           = EW + CW;         // |det| width
    localparam int DETW         = MW + 1;          // signed det width
    localparam int DW           = MW + 1;          // divisor 2*|det|
    localparam int QW           = EW + 1;          // quotient bits kept
    localparam int RW           = DW + QW - 1;     // remainder width
    localparam int NSH          = 2 * FRAC_BITS + 1;
    localparam int NLANE        = 9;
    localparam int NPIV         = 3;
    localparam int FRONT_STAGES = 6;
    localparam int QDEPTH       = 8;
    localparam int QAW          = $clog2(QDEPTH);
    localparam int QCW          = $clog2(QDEPTH + 1);

    localparam logic [EW-1:0] SAT_POS = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] SAT_NEG = {1'b1, {(EW-1){1'b0}}};

    // cofactor k = m[a]*m[b] - m[c]*m[d], column-major element indexes
    localparam int unsigned COF_IDX [NLANE][4] = '{
        '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
        '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
        '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
    };
    // elements of row 0 that pair with cofactors 0..2 for the determinant
    localparam int unsigned PIV_IDX [NPIV] = '{0, 3, 6};

    typedef struct packed {
        logic signed [EW-1:0] in_c0r0;
        logic signed [EW-1:0] in_c0r1;
        logic signed [EW-1:0] in_c0r2;
        logic signed [EW-1:0] in_c1r0;
        logic signed [EW-1:0] in_c1r1;
        logic signed [EW-1:0] in_c1r2;
        logic signed [EW-1:0] in_c2r0;
        logic signed [EW-1:0] in_c2r1;
        logic signed [EW-1:0] in_c2r2;
    } t_in;

    typedef struct packed {
        logic signed [EW-1:0] inv_c0r0;
        logic signed [EW-1:0] inv_c0r1;
        logic signed [EW-1:0] inv_c0r2;
        logic signed [EW-1:0] inv_c1r0;
        logic signed [EW-1:0] inv_c1r1;
        logic signed [EW-1:0] inv_c1r2;
        logic signed [EW-1:0] inv_c2r0;
        logic signed [EW-1:0] inv_c2r1;
        logic signed [EW-1:0] inv_c2r2;
        logic signed [EW-1:0] determinant;
        logic                 singular;
    } t_out;

    // classified request handed from front to back
    typedef struct packed {
        logic [NLANE-1:0][CW-1:0] cof;
        logic [MW-1:0]            dmag;
        logic                     dneg;
        logic                     singular;
        logic [EW-1:0]            det_q;
    } t_cls;

    // saturate a rounded magnitude to a signed EW-bit code
    function automatic logic [EW-1:0] sat_round(input logic neg, input logic big,
                                                input logic [QW-1:0] mag);
        logic [QW-1:0] neg_mag;
        logic [EW-1:0] res;
        neg_mag = ~mag + QW'(1);
        if (neg) begin
            if (big || mag > {1'b0, SAT_NEG}) res = SAT_NEG;
            else res = neg_mag[EW-1:0];
        end else begin
            if (big || mag[QW-1:EW-1] != '0) res = SAT_POS;
            else res = mag[EW-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/m3inv_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_front: cofactor and determinant pipeline
// Forms the nine cofactors and the exact determinant, classifies the matrix.
// ----------------------------------------------------------------------------
module m3inv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  m3inv_pkg::t_in      i_item,
    output logic                o_vld,
    output m3inv_pkg::t_cls     o_cls
);

    logic signed [m3inv_pkg::EW-1:0]   w_m [m3inv_pkg::NLANE];
    logic [m3inv_pkg::FRONT_STAGES-1:0] r_vld;

    logic signed [m3inv_pkg::CW-1:0]   r_pp1 [m3inv_pkg::NLANE][2];
    logic signed [m3inv_pkg::EW-1:0]   r_piv1 [m3inv_pkg::NPIV];
    logic signed [m3inv_pkg::CW-1:0]   r_cof2 [m3inv_pkg::NLANE];
    logic signed [m3inv_pkg::EW-1:0]   r_piv2 [m3inv_pkg::NPIV];
    logic signed [m3inv_pkg::CW:0]     r_lo3 [m3inv_pkg::NPIV];
    logic signed [m3inv_pkg::CW-1:0]   r_hi3 [m3inv_pkg::NPIV];
    logic signed [m3inv_pkg::CW-1:0]   r_cof3 [m3inv_pkg::NLANE];
    logic signed [m3inv_pkg::DETW-1:0] r_prod4 [m3inv_pkg::NPIV];
    logic signed [m3inv_pkg::CW-1:0]   r_cof4 [m3inv_pkg::NLANE];
    logic signed [m3inv_pkg::DETW-1:0] r_det5;
    logic signed [m3inv_pkg::CW-1:0]   r_cof5 [m3inv_pkg::NLANE];
    m3inv_pkg::t_cls                   r_cls6;

    logic                              w_dneg;
    logic [m3inv_pkg::DETW-1:0]        w_dabs;
    logic [m3inv_pkg::DETW-1:0]        w_rnd;
    logic [m3inv_pkg::DETW-1:0]        w_sh;

    assign w_m[0] = i_item.in_c0r0;
    assign w_m[1] = i_item.in_c0r1;
    assign w_m[2] = i_item.in_c0r2;
    assign w_m[3] = i_item.in_c1r0;
    assign w_m[4] = i_item.in_c1r1;
    assign w_m[5] = i_item.in_c1r2;
    assign w_m[6] = i_item.in_c2r0;
    assign w_m[7] = i_item.in_c2r1;
    assign w_m[8] = i_item.in_c2r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[m3inv_pkg::FRONT_STAGES-2:0], i_vld};
        end
    end

    for (genvar k = 0; k < m3inv_pkg::NLANE; k++) begin : g_cof
        always_ff @(posedge i_clk) begin
            r_pp1[k][0] <= w_m[m3inv_pkg::COF_IDX[k][0]] * w_m[m3inv_pkg::COF_IDX[k][1]];
            r_pp1[k][1] <= w_m[m3inv_pkg::COF_IDX[k][2]] * w_m[m3inv_pkg::COF_IDX[k][3]];
            r_cof2[k]   <= r_pp1[k][0] - r_pp1[k][1];
            r_cof3[k]   <= r_cof2[k];
            r_cof4[k]   <= r_cof3[k];
            r_cof5[k]   <= r_cof4[k];
        end
    end

    // split each row-0 product into 32x32 halves, then recombine
    for (genvar j = 0; j < m3inv_pkg::NPIV; j++) begin : g_piv
        always_ff @(posedge i_clk) begin
            r_piv1[j]  <= w_m[m3inv_pkg::PIV_IDX[j]];
            r_piv2[j]  <= r_piv1[j];
            r_lo3[j]   <= r_piv2[j] * $signed({1'b0, r_cof2[j][m3inv_pkg::EW-1:0]});
            r_hi3[j]   <= r_piv2[j] * $signed(r_cof2[j][m3inv_pkg::CW-1:m3inv_pkg::EW]);
            r_prod4[j] <= (m3inv_pkg::DETW'(r_hi3[j]) <<< m3inv_pkg::EW)
                        + m3inv_pkg::DETW'(r_lo3[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_det5 <= r_prod4[0] + r_prod4[1] + r_prod4[2];
    end

    // classify: sign, magnitude, rounded determinant
    always_comb begin
        w_dneg = r_det5[m3inv_pkg::DETW-1];
        w_dabs = w_dneg ? (~r_det5 + m3inv_pkg::DETW'(1)) : r_det5;
        w_rnd  = w_dabs + (m3inv_pkg::DETW'(1) << (2 * m3inv_pkg::FRAC_BITS - 1));
        w_sh   = w_rnd >> (2 * m3inv_pkg::FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < m3inv_pkg::NLANE; k++) begin
            r_cls6.cof[k] <= r_cof5[k];
        end
        r_cls6.dmag     <= w_dabs[m3inv_pkg::MW-1:0];
        r_cls6.dneg     <= w_dneg;
        r_cls6.singular <= (r_det5 == '0);
        r_cls6.det_q    <= m3inv_pkg::sat_round(w_dneg,
                               |w_sh[m3inv_pkg::DETW-1:m3inv_pkg::QW],
                               w_sh[m3inv_pkg::QW-1:0]);
    end

    assign o_vld = r_vld[m3inv_pkg::FRONT_STAGES-1];
    assign o_cls = r_cls6;

endmodule

// ----- rtl/m3inv_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_queue: decoupling queue between front and back
// Short register queue of classified requests.
// ----------------------------------------------------------------------------
module m3inv_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  m3inv_pkg::t_cls   i_data,
    input  logic              i_rd,
    output logic              o_vld,
    output m3inv_pkg::t_cls   o_data
);

    m3inv_pkg::t_cls             r_mem [m3inv_pkg::QDEPTH];
    logic [m3inv_pkg::QAW-1:0]   r_wp;
    logic [m3inv_pkg::QAW-1:0]   r_rp;
    logic [m3inv_pkg::QCW-1:0]   r_cnt;
    logic                        w_full;

    assign w_full = (r_cnt == m3inv_pkg::QCW'(m3inv_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + m3inv_pkg::QAW'(1);
            if (i_rd) r_rp <= r_rp + m3inv_pkg::QAW'(1);
            r_cnt <= r_cnt + m3inv_pkg::QCW'(i_wr) - m3inv_pkg::QCW'(i_rd);
        end
    end

    assign o_vld  = (r_cnt != '0);
    assign o_data = r_mem[r_rp];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && w_full && !i_rd))
        else $error("request written into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && !o_vld))
        else $error("request taken from an empty queue");
`endif

endmodule

// ----- rtl/m3inv_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_back: divider lanes and result register
// Nine restoring dividers, one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module m3inv_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  m3inv_pkg::t_cls   i_cls,
    output logic              o_take,
    input  logic              i_pop,
    output logic              o_empty,
    output m3inv_pkg::t_out   o_result
);

    localparam int NS = m3inv_pkg::QW;

    logic                          w_adv;
    logic [NS:0]                   r_sv;
    logic [m3inv_pkg::RW-1:0]      r_rem [NS+1][m3inv_pkg::NLANE];
    logic [m3inv_pkg::QW-1:0]      r_q   [NS+1][m3inv_pkg::NLANE];
    logic                          r_neg [NS+1][m3inv_pkg::NLANE];
    logic [m3inv_pkg::DW-1:0]      r_den [NS+1];
    logic                          r_sing [NS+1];
    logic [m3inv_pkg::EW-1:0]      r_detq [NS+1];
    logic [m3inv_pkg::CW-1:0]      w_nmag [m3inv_pkg::NLANE];
    logic [m3inv_pkg::EW-1:0]      w_inv  [m3inv_pkg::NLANE];
    logic                          r_ovld;
    m3inv_pkg::t_out               r_out;
    m3inv_pkg::t_out               n_out;

    // the whole lane pipeline moves unless a finished result is held
    assign w_adv  = !r_ovld || i_pop;
    assign o_take = w_adv && i_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv   <= '0;
            r_ovld <= 1'b0;
        end else if (w_adv) begin
            r_sv   <= {r_sv[NS-1:0], i_vld};
            r_ovld <= r_sv[NS];
        end
    end

    // load: numerator |n| * 2^(2F+1) + |det|, divisor 2*|det|
    for (genvar k = 0; k < m3inv_pkg::NLANE; k++) begin : g_load
        assign w_nmag[k] = i_cls.cof[k][m3inv_pkg::CW-1]
                         ? (~i_cls.cof[k] + m3inv_pkg::CW'(1)) : i_cls.cof[k];
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rem[0][k] <= (m3inv_pkg::RW'(w_nmag[k]) << m3inv_pkg::NSH)
                             + m3inv_pkg::RW'(i_cls.dmag);
                r_q[0][k]   <= '0;
                r_neg[0][k] <= i_cls.cof[k][m3inv_pkg::CW-1] ^ i_cls.dneg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_den[0]  <= {i_cls.dmag, 1'b0};
            r_sing[0] <= i_cls.singular;
            r_detq[0] <= i_cls.det_q;
        end
    end

    // stage s decides quotient bit NS-s; the top bit flags overflow
    for (genvar s = 1; s <= NS; s++) begin : g_stage
        localparam int SH = NS - s;
        logic [m3inv_pkg::RW-1:0] w_dsh;
        assign w_dsh = m3inv_pkg::RW'(r_den[s-1]) << SH;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_den[s]  <= r_den[s-1];
                r_sing[s] <= r_sing[s-1];
                r_detq[s] <= r_detq[s-1];
            end
        end

        for (genvar k = 0; k < m3inv_pkg::NLANE; k++) begin : g_lane
            logic w_ge;
            assign w_ge = (r_rem[s-1][k] >= w_dsh);
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_rem[s][k] <= w_ge ? (r_rem[s-1][k] - w_dsh) : r_rem[s-1][k];
                    r_q[s][k]   <= {r_q[s-1][k][m3inv_pkg::QW-2:0], w_ge};
                    r_neg[s][k] <= r_neg[s-1][k];
                end
            end
        end
    end

    for (genvar k = 0; k < m3inv_pkg::NLANE; k++) begin : g_sat
        assign w_inv[k] = r_sing[NS] ? '0 : m3inv_pkg::sat_round(r_neg[NS][k],
                              r_q[NS][k][m3inv_pkg::QW-1],
                              {1'b0, r_q[NS][k][m3inv_pkg::EW-1:0]});
    end

    always_comb begin
        n_out.inv_c0r0    = w_inv[0];
        n_out.inv_c0r1    = w_inv[1];
        n_out.inv_c0r2    = w_inv[2];
        n_out.inv_c1r0    = w_inv[3];
        n_out.inv_c1r1    = w_inv[4];
        n_out.inv_c1r2    = w_inv[5];
        n_out.inv_c2r0    = w_inv[6];
        n_out.inv_c2r1    = w_inv[7];
        n_out.inv_c2r2    = w_inv[8];
        n_out.determinant = r_sing[NS] ? '0 : r_detq[NS];
        n_out.singular    = r_sing[NS];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_empty  = !r_ovld;
    assign o_result = r_out;

endmodule

// ----- rtl/matrix3_inverse_adjugate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_adjugate: 3x3 signed fixed-point inverse by the adjugate
// Front computes cofactors and determinant, back runs nine dividers.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload                 direction
//  -------   --------------   ---------------------   ---------
//  request   push / full      i_item   (t_in)         in
//  result    empty / pop      o_result (t_out)        out
//
//  One request accepted per cycle sustained while results are popped. A
//  request passes the cofactor/determinant pipeline, the queue, one load
//  stage, 33 restoring-divider stages (one quotient bit each) and the
//  result register. Synchronous active-low reset empties every stage.
//  The front never stalls: full is raised from a credit count over front
//  and queue. A held result freezes the load stage, dividers and result.
// ----------------------------------------------------------------------------
module matrix3_inverse_adjugate (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  m3inv_pkg::t_in    i_item,
    output logic              empty,
    input  logic              pop,
    output m3inv_pkg::t_out   o_result
);

    logic                        w_acc;
    logic                        w_fvld;
    m3inv_pkg::t_cls             w_fcls;
    logic                        w_qvld;
    m3inv_pkg::t_cls             w_qcls;
    logic                        w_take;
    logic [m3inv_pkg::QCW-1:0]   r_occ;

    // accept a request only when a queue slot is reserved for it
    assign full  = (r_occ == m3inv_pkg::QCW'(m3inv_pkg::QDEPTH));
    assign w_acc = push && !full;

    // hold the credit: requests in the front plus requests in the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= r_occ + m3inv_pkg::QCW'(w_acc) - m3inv_pkg::QCW'(w_take);
        end
    end

    m3inv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_acc),
        .i_item  (i_item),
        .o_vld   (w_fvld),
        .o_cls   (w_fcls)
    );

    m3inv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_fvld),
        .i_data  (w_fcls),
        .i_rd    (w_take),
        .o_vld   (w_qvld),
        .o_data  (w_qcls)
    );

    m3inv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_qvld),
        .i_cls    (w_qcls),
        .o_take   (w_take),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= m3inv_pkg::QCW'(m3inv_pkg::QDEPTH))
        else $error("credit count above queue depth");
    a_credit_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> r_occ != '0)
        else $error("queue drained with no credit outstanding");
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.singular) |-> (o_result.determinant == '0
            && o_result.inv_c0r0 == '0 && o_result.inv_c1r1 == '0
            && o_result.inv_c2r2 == '0))
        else $error("singular result with nonzero fields");
`endif

endmodule
